/* design/i2cmbe_pkg.sv */
// Package for the I2C master bit engine.
// Holds command codes, register indexes, phase hold values and the delay timer control type.
// No dependencies.
package i2cmbe_pkg;

  // Command codes carried in the func field.
  localparam logic [2:0] FUNC_START    = 3'd0;
  localparam logic [2:0] FUNC_STOP     = 3'd1;
  localparam logic [2:0] FUNC_WRITE    = 3'd2;
  localparam logic [2:0] FUNC_READ     = 3'd3;
  localparam logic [2:0] FUNC_WAIT_ACK = 3'd4;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [15:0] TICKS_RESET   = 16'd80;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd250;

  // Phase hold lengths in delay units.
  localparam logic [3:0] HOLD_0  = 4'd0;
  localparam logic [3:0] HOLD_1  = 4'd1;
  localparam logic [3:0] HOLD_2  = 4'd2;
  localparam logic [3:0] HOLD_10 = 4'd10;

  // Phase step counter and notable steps within each command.
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_BITS_END = 5'd16;
  localparam logic [STEP_W-1:0] STEP_ACK_DRV  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_ACK_HIGH = 5'd18;
  localparam logic [STEP_W-1:0] STEP_READ_END = 5'd19;
  localparam logic [STEP_W-1:0] STEP_POLL_END = 5'd3;

  // Control handed from the sequencer to the delay timer.
  typedef struct packed {
    logic       load;
    logic [3:0] units;
  } dly_ctl_t;

endpackage

/* design/i2cmbe_if.sv */
// Channel interfaces of the I2C master bit engine: command input, phase output, configuration.
// Depends on i2cmbe_pkg.
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] wr_data;
  logic       send_ack;
  logic [7:0] slave_bits;
  logic [7:0] ack_polls_high;

  modport source (output valid, func, wr_data, send_ack, slave_bits, ack_polls_high,
                  input ready);
  modport sink   (input valid, func, wr_data, send_ack, slave_bits, ack_polls_high,
                  output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_is_input;
  logic [3:0] hold_units;
  logic [7:0] read_byte;
  logic       ack_ok;
  logic       last;

  modport source (output valid, scl_level, sda_level, sda_is_input, hold_units, read_byte,
                         ack_ok, last,
                  input ready);
  modport sink   (input valid, scl_level, sda_level, sda_is_input, hold_units, read_byte,
                        ack_ok, last,
                  output ready);
endinterface

interface i2cmbe_cfg_if import i2cmbe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/i2c_master_bit_engine_top.sv */
// Top level of the I2C master bit engine: command sequencer, phase output register and registers.
// Depends on i2cmbe_pkg, the channel interfaces and i2cmbe_delay.
// Each phase is issued through the output register, then the delay timer holds it for
// hold_units delay units, with the unit length set by ticks_per_delay_unit.
// A command takes 3 to 20 phases; a write byte holds for 34 delay units in all.
// One command at a time: the input is ready only while the sequencer is idle.
// Synchronous reset leaves SCL and SDA high, SDA driven, registers at 80 and 250.
module i2c_master_bit_engine_top import i2cmbe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  i2cmbe_in_if.sink    in_ch,
  i2cmbe_out_if.source out_ch,
  i2cmbe_cfg_if.sink   cfg_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  timeout_r, timeout_nxt;

  // Command held for the length of its phase run.
  logic [2:0]        func_r, func_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              ack_r, ack_nxt;
  logic [7:0]        sbits_r, sbits_nxt;
  logic              fail_r, fail_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last_r, last_nxt;

  // Line state and received byte.
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       rel_r, rel_nxt;
  logic [7:0] shreg_r, shreg_nxt;

  // Output register.
  logic       ov_r, ov_nxt;
  logic       o_scl_r, o_scl_nxt;
  logic       o_sda_r, o_sda_nxt;
  logic       o_rel_r, o_rel_nxt;
  logic [3:0] o_hold_r, o_hold_nxt;
  logic [7:0] o_rbyte_r, o_rbyte_nxt;
  logic       o_ackok_r, o_ackok_nxt;
  logic       o_last_r, o_last_nxt;

  // Phase generator results.
  logic       ph_scl, ph_sda, ph_rel, ph_last, ph_ackok;
  logic [3:0] ph_hold;
  logic [7:0] ph_rbyte, ph_shreg, ph_data, ph_sbits;
  logic       do_stop;
  logic [1:0] stop_idx;

  logic     in_acc, out_free, load;
  dly_ctl_t dly_ctl;
  logic     dly_done;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign load     = (state_r == ST_RUN) && out_free;

  // Phase generator: the levels and hold of the phase at the current step.
  always_comb begin
    ph_scl   = scl_r;
    ph_sda   = sda_r;
    ph_rel   = rel_r;
    ph_hold  = HOLD_0;
    ph_last  = 1'b0;
    ph_ackok = 1'b0;
    ph_rbyte = '0;
    ph_shreg = shreg_r;
    ph_data  = data_r;
    ph_sbits = sbits_r;
    do_stop  = 1'b0;
    stop_idx = 2'd0;
    case (func_r)
      FUNC_START: begin
        case (step_r)
          5'd0: begin
            ph_rel  = 1'b0;
            ph_sda  = 1'b1;
            ph_scl  = 1'b1;
            ph_hold = HOLD_2;
          end
          5'd1: begin
            ph_sda  = 1'b0;
            ph_hold = HOLD_2;
          end
          default: begin
            ph_scl  = 1'b0;
            ph_hold = HOLD_10;
            ph_last = 1'b1;
          end
        endcase
      end
      FUNC_STOP: begin
        do_stop  = 1'b1;
        stop_idx = step_r[1:0];
      end
      FUNC_WRITE: begin
        ph_rel  = 1'b0;
        ph_hold = HOLD_2;
        if (step_r == STEP_BITS_END) begin
          ph_scl  = 1'b0;
          ph_last = 1'b1;
        end else if (!step_r[0]) begin
          ph_scl  = 1'b0;
          ph_sda  = data_r[7];
          ph_data = {data_r[6:0], 1'b0};
        end else begin
          ph_scl = 1'b1;
        end
      end
      FUNC_READ: begin
        if (step_r < STEP_BITS_END) begin
          ph_rel  = 1'b1;
          ph_hold = HOLD_2;
          if (!step_r[0]) begin
            ph_scl = 1'b0;
            if (step_r == '0) begin
              ph_shreg = '0;
            end
          end else begin
            ph_scl   = 1'b1;
            ph_shreg = {shreg_r[6:0], sbits_r[7]};
            ph_sbits = {sbits_r[6:0], 1'b0};
          end
        end else if (step_r == STEP_BITS_END) begin
          ph_scl = 1'b0;
        end else if (step_r == STEP_ACK_DRV) begin
          ph_rel  = 1'b0;
          ph_sda  = !ack_r;
          ph_hold = HOLD_2;
        end else if (step_r == STEP_ACK_HIGH) begin
          ph_scl  = 1'b1;
          ph_hold = HOLD_2;
        end else begin
          ph_scl   = 1'b0;
          ph_last  = 1'b1;
          ph_rbyte = shreg_r;
        end
      end
      FUNC_WAIT_ACK: begin
        case (step_r)
          5'd0: begin
            ph_sda  = 1'b1;
            ph_hold = HOLD_1;
          end
          5'd1: begin
            ph_rel  = 1'b1;
            ph_hold = HOLD_1;
          end
          5'd2: begin
            ph_scl  = 1'b1;
            ph_hold = HOLD_2;
          end
          default: begin
            if (fail_r) begin
              do_stop  = 1'b1;
              stop_idx = 2'(step_r - STEP_POLL_END);
            end else begin
              ph_scl   = 1'b0;
              ph_rel   = 1'b0;
              ph_last  = 1'b1;
              ph_ackok = 1'b1;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    // Stop condition, shared by the stop command and a timed out wait for ACK.
    if (do_stop) begin
      case (stop_idx)
        2'd0: begin
          ph_rel  = 1'b0;
          ph_sda  = 1'b0;
          ph_hold = HOLD_2;
        end
        2'd1: begin
          ph_scl  = 1'b1;
          ph_hold = HOLD_2;
        end
        default: begin
          ph_sda  = 1'b1;
          ph_last = 1'b1;
        end
      endcase
    end
  end

  // Sequencer next state, configuration writes and output register.
  always_comb begin
    state_nxt   = state_r;
    ticks_nxt   = ticks_r;
    timeout_nxt = timeout_r;
    func_nxt    = func_r;
    data_nxt    = data_r;
    ack_nxt     = ack_r;
    sbits_nxt   = sbits_r;
    fail_nxt    = fail_r;
    step_nxt    = step_r;
    last_nxt    = last_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    rel_nxt     = rel_r;
    shreg_nxt   = shreg_r;
    ov_nxt      = ov_r && !out_ch.ready;
    o_scl_nxt   = o_scl_r;
    o_sda_nxt   = o_sda_r;
    o_rel_nxt   = o_rel_r;
    o_hold_nxt  = o_hold_r;
    o_rbyte_nxt = o_rbyte_r;
    o_ackok_nxt = o_ackok_r;
    o_last_nxt  = o_last_r;
    dly_ctl     = '{load: 1'b0, units: HOLD_0};

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TICKS:   ticks_nxt   = cfg_ch.data;
        CFG_TIMEOUT: timeout_nxt = cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_ch.func;
          data_nxt  = in_ch.wr_data;
          ack_nxt   = in_ch.send_ack;
          sbits_nxt = in_ch.slave_bits;
          fail_nxt  = in_ch.ack_polls_high > timeout_r;
          step_nxt  = '0;
          if (in_ch.func <= FUNC_WAIT_ACK) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_scl_nxt   = ph_scl;
          o_sda_nxt   = ph_rel ? 1'b1 : ph_sda;
          o_rel_nxt   = ph_rel;
          o_hold_nxt  = ph_hold;
          o_rbyte_nxt = ph_rbyte;
          o_ackok_nxt = ph_ackok;
          o_last_nxt  = ph_last;
          scl_nxt     = ph_scl;
          sda_nxt     = ph_sda;
          rel_nxt     = ph_rel;
          shreg_nxt   = ph_shreg;
          data_nxt    = ph_data;
          sbits_nxt   = ph_sbits;
          step_nxt    = step_r + 5'd1;
          last_nxt    = ph_last;
          dly_ctl     = '{load: 1'b1, units: ph_hold};
          state_nxt   = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (dly_done) begin
          state_nxt = last_r ? ST_IDLE : ST_RUN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ticks_r   <= TICKS_RESET;
      timeout_r <= TIMEOUT_RESET;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      rel_r     <= 1'b0;
      shreg_r   <= '0;
      ov_r      <= 1'b0;
      last_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      ticks_r   <= ticks_nxt;
      timeout_r <= timeout_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      rel_r     <= rel_nxt;
      shreg_r   <= shreg_nxt;
      ov_r      <= ov_nxt;
      last_r    <= last_nxt;
      step_r    <= step_nxt;
    end
    func_r    <= func_nxt;
    data_r    <= data_nxt;
    ack_r     <= ack_nxt;
    sbits_r   <= sbits_nxt;
    fail_r    <= fail_nxt;
    o_scl_r   <= o_scl_nxt;
    o_sda_r   <= o_sda_nxt;
    o_rel_r   <= o_rel_nxt;
    o_hold_r  <= o_hold_nxt;
    o_rbyte_r <= o_rbyte_nxt;
    o_ackok_r <= o_ackok_nxt;
    o_last_r  <= o_last_nxt;
  end

  // Phase hold timer.
  i2cmbe_delay u_delay (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (dly_ctl),
    .ticks_per_unit (ticks_r),
    .done           (dly_done)
  );

  // Channel outputs.
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ov_r;
  assign out_ch.scl_level    = o_scl_r;
  assign out_ch.sda_level    = o_sda_r;
  assign out_ch.sda_is_input = o_rel_r;
  assign out_ch.hold_units   = o_hold_r;
  assign out_ch.read_byte    = o_rbyte_r;
  assign out_ch.ack_ok       = o_ackok_r;
  assign out_ch.last         = o_last_r;

  // A new phase is only issued once the previous hold has run out.
  a_load_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> dly_done)
    else $error("phase issued while the previous hold was still running");

  // No command runs past the read byte, its longest phase run.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= STEP_READ_END))
    else $error("phase step beyond the longest command");

  // A released data line always reads as high.
  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_rel_r) |-> o_sda_r)
    else $error("released SDA shown as driven low");

  // The last phase of a command returns the sequencer to idle once its hold ends.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_HOLD) && last_r && dly_done) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after the last phase");

endmodule

/* design/i2cmbe_delay.sv */
// Delay timer of the I2C master bit engine: holds a phase for a number of delay units.
// Depends on i2cmbe_pkg.
module i2cmbe_delay import i2cmbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dly_ctl_t    ctl,
  input  logic [15:0] ticks_per_unit,
  output logic        done
);

  logic [3:0]  unit_cnt_r, unit_cnt_nxt;
  logic [15:0] tick_cnt_r, tick_cnt_nxt;
  logic [16:0] tick_inc;

  // Count clock ticks within a unit and units within the phase.
  assign tick_inc = {1'b0, tick_cnt_r} + 17'd1;

  always_comb begin
    unit_cnt_nxt = unit_cnt_r;
    tick_cnt_nxt = tick_cnt_r;
    if (ctl.load) begin
      unit_cnt_nxt = ctl.units;
      tick_cnt_nxt = '0;
    end else if (unit_cnt_r != '0) begin
      if (tick_inc >= {1'b0, ticks_per_unit}) begin
        tick_cnt_nxt = '0;
        unit_cnt_nxt = unit_cnt_r - 4'd1;
      end else begin
        tick_cnt_nxt = tick_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_cnt_r <= '0;
      tick_cnt_r <= '0;
    end else begin
      unit_cnt_r <= unit_cnt_nxt;
      tick_cnt_r <= tick_cnt_nxt;
    end
  end

  assign done = (unit_cnt_r == '0);

endmodule
